// File: src/pcc_pkg.sv
package pcc_pkg;

  localparam int unsigned PosW   = 11;
  localparam int unsigned CountW = 20;
  localparam logic [CountW-1:0] CountMax = '1;

  // sequencer states
  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_CMP   = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } pcc_state_e;

  // find steps: four for the clash check, two per merge
  localparam logic [2:0] StepChk0 = 3'd0;
  localparam logic [2:0] StepChk3 = 3'd3;
  localparam logic [2:0] StepMrg0 = 3'd5;
  localparam logic [2:0] StepMrg1 = 3'd7;

endpackage

// File: src/pcc_store.sv
module pcc_store #(
  parameter int unsigned Depth = 2050,
  parameter int unsigned IdxW  = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output logic [IdxW-1:0] rd_data_o,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  logic [IdxW-1:0] wr_data_i,
  output logic            init_done_o
);

  logic [IdxW-1:0] mem [Depth];
  logic [IdxW-1:0] sweep_q, sweep_d;
  logic            done_q, done_d;
  logic [IdxW-1:0] rd_data_q;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  always_comb begin
    sweep_d = sweep_q;
    done_d  = done_q;
    if (!done_q) begin
      sweep_d = sweep_q + 1'b1;
      if (sweep_q == LastIdx) done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
      done_q  <= 1'b0;
    end else begin
      sweep_q <= sweep_d;
      done_q  <= done_d;
    end
  end

  // each entry starts pointing to itself
  always_ff @(posedge clk_i) begin
    if (!done_q) begin
      mem[sweep_q] <= sweep_q;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o   = rd_data_q;
  assign init_done_o = done_q;

endmodule

// File: src/parity_constraint_checker_unit.sv
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_stall_o  | left_pos_i, right_pos_i, claims_odd_i
// out     | output    | out_valid_o / out_stall_i| consistent_o, contradiction_seen_o,
//         |           |                          | consistent_count_o
// one transaction at a time; a root walk reads and compares each node visited, root
// included; each merge ends in a write to the parent store
// accepted claim: eight root walks and two merge writes
// clashing claim: the four walks of the clash check, then the result
// after a contradiction a claim goes straight to the result with no walk
// after reset the parent store is swept with in_stall_o high
// a result waits in the output register while out_stall_i is high; the next claim is
// processed meanwhile and holds in its last cycle until the register frees
module parity_constraint_checker_unit #(
  parameter int unsigned MAX_POS = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [pcc_pkg::PosW-1:0]  left_pos_i,
  input  logic [pcc_pkg::PosW-1:0]  right_pos_i,
  input  logic                      claims_odd_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      consistent_o,
  output logic                      contradiction_seen_o,
  output logic [pcc_pkg::CountW-1:0] consistent_count_o
);
  import pcc_pkg::*;

  localparam int unsigned Nodes = MAX_POS + 1;
  localparam int unsigned Depth = 2 * Nodes;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam logic [IdxW-1:0] NodesIdx = IdxW'(Nodes);

  pcc_state_e state_q, state_d;
  logic [2:0]        step_q, step_d;
  logic [IdxW-1:0]   cur_q, cur_d;
  logic [IdxW-1:0]   u_q, v_q;
  logic              odd_q;
  logic [IdxW-1:0]   root_q [3];
  logic              conflict_q, conflict_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              ok_q, ok_d;
  logic              ovalid_q, ovalid_d;
  logic              res_ok_q, res_ok_d;
  logic              res_seen_q, res_seen_d;
  logic [CountW-1:0] res_cnt_q, res_cnt_d;

  logic            rd_en, wr_en, init_done;
  logic [IdxW-1:0] rd_data, wr_addr, wr_data;
  logic            in_acc, root_hit;
  logic [IdxW-1:0] u_new, v_new;

  pcc_store #(.Depth(Depth), .IdxW(IdxW)) u_store (
    .clk_i, .rst_ni,
    .rd_en_i(rd_en), .rd_addr_i(cur_q), .rd_data_o(rd_data),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data),
    .init_done_o(init_done)
  );

  function automatic logic [IdxW-1:0] clamp_pos(input logic [PosW-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    if (w < 32'd1) w = 32'd1;
    if (w > 32'(MAX_POS)) w = 32'(MAX_POS);
    return IdxW'(w);
  endfunction

  // node walked at each step
  function automatic logic [IdxW-1:0] tgt_next(input logic [2:0] s);
    logic [IdxW-1:0] r;
    unique case (s)
      3'd0, 3'd4: r = u_q;
      3'd2, 3'd6: r = u_q + NodesIdx;
      3'd1, 3'd7: r = odd_q ? v_q : v_q + NodesIdx;
      default:    r = odd_q ? v_q + NodesIdx : v_q;
    endcase
    return r;
  endfunction

  assign u_new = clamp_pos(left_pos_i) - 1'b1;
  assign v_new = clamp_pos(right_pos_i);

  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign root_hit = (rd_data == cur_q);
  assign rd_en    = (state_q == S_READ);
  assign wr_en    = (state_q == S_WRITE);
  assign wr_addr  = root_q[0];
  assign wr_data  = root_q[1];

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cur_d      = cur_q;
    conflict_d = conflict_q;
    cnt_d      = cnt_q;
    ok_d       = ok_q;
    ovalid_d   = ovalid_q;
    res_ok_d   = res_ok_q;
    res_seen_d = res_seen_q;
    res_cnt_d  = res_cnt_q;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    unique case (state_q)
      S_INIT: if (init_done) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          step_d  = StepChk0;
          ok_d    = 1'b0;
          state_d = conflict_q ? S_DONE : S_READ;
          cur_d   = u_new;
        end
      end
      S_READ: state_d = S_CMP;
      S_CMP: begin
        if (!root_hit) begin
          cur_d   = rd_data;
          state_d = S_READ;
        end else begin
          step_d = step_q + 1'b1;
          state_d = S_READ;
          if (step_q == StepChk3) begin
            if (root_q[0] == root_q[1] || root_q[2] == cur_q) begin
              conflict_d = 1'b1;
              state_d    = S_DONE;
            end
          end else if (step_q == StepMrg0 || step_q == StepMrg1) begin
            state_d = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        if (step_q == StepChk0) begin
          ok_d = 1'b1;
          if (cnt_q != CountMax) cnt_d = cnt_q + 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_READ;
        end
      end
      S_DONE: begin
        if (!ovalid_d) begin
          ovalid_d   = 1'b1;
          res_ok_d   = ok_q;
          res_seen_d = conflict_q;
          res_cnt_d  = cnt_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
    // next walk starts at its own node
    if ((state_q == S_CMP && root_hit) || state_q == S_WRITE) cur_d = tgt_next(step_d);
    if (state_q == S_IDLE) cur_d = u_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      step_q     <= '0;
      conflict_q <= 1'b0;
      cnt_q      <= '0;
      ovalid_q   <= 1'b0;
      ok_q       <= 1'b0;
      res_ok_q   <= 1'b0;
      res_seen_q <= 1'b0;
      res_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      conflict_q <= conflict_d;
      cnt_q      <= cnt_d;
      ovalid_q   <= ovalid_d;
      ok_q       <= ok_d;
      res_ok_q   <= res_ok_d;
      res_seen_q <= res_seen_d;
      res_cnt_q  <= res_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (in_acc) begin
      u_q   <= u_new;
      v_q   <= v_new;
      odd_q <= claims_odd_i;
    end
    // check roots land in slots 0..2, merge roots alternate between slots 0 and 1
    if (state_q == S_CMP && root_hit) begin
      if (step_q < StepChk3) root_q[step_q[1:0]] <= cur_q;
      else if (step_q > StepChk3) root_q[{1'b0, step_q[0]}] <= cur_q;
    end
  end

  assign out_valid_o          = ovalid_q;
  assign consistent_o         = res_ok_q;
  assign contradiction_seen_o = res_seen_q;
  assign consistent_count_o   = res_cnt_q;

  a_latch_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conflict_q |=> conflict_q) else $error("contradiction flag cleared");
  a_init_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_done |-> in_stall_o) else $error("claim taken during sweep");
  a_ok_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && consistent_o) |-> !contradiction_seen_o)
    else $error("accepted claim with contradiction");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> $past(state_q == S_WRITE))
    else $error("count moved outside merge");

endmodule

// File: tb/sv/parity_constraint_checker_unit_test.sv
module parity_constraint_checker_unit_test;
  import pcc_pkg::*;

  localparam int unsigned MaxPos = 1024;
  localparam int unsigned Nodes = MaxPos + 1;
  localparam int unsigned Depth = 2 * Nodes;
  localparam int unsigned LongHold = 400;

  typedef struct packed {
    logic              consistent;
    logic              seen;
    logic [CountW-1:0] count;
  } verdict_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [PosW-1:0]   left_pos_i;
  logic [PosW-1:0]   right_pos_i;
  logic              claims_odd_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              consistent_o;
  logic              contradiction_seen_o;
  logic [CountW-1:0] consistent_count_o;

  parity_constraint_checker_unit #(.MAX_POS(MaxPos)) dut (.*);

  // predictor state
  int unsigned       parent_tbl[Depth];
  bit                clash_latched;
  logic [CountW-1:0] accepted_cnt;
  verdict_t          verdicts_q[$];

  // hidden bit string; prefix parity at every node
  bit                prefix_par[Nodes];

  int unsigned       error_cnt;
  int unsigned       claims_sent;
  int unsigned       results_seen;
  bit                no_idle;
  bit                hold_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #400000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned find_root(int unsigned n);
    int unsigned r;
    int unsigned cur;
    int unsigned nxt;
    r = n;
    while (parent_tbl[r] != r) r = parent_tbl[r];
    cur = n;
    while (parent_tbl[cur] != r) begin
      nxt = parent_tbl[cur];
      parent_tbl[cur] = r;
      cur = nxt;
    end
    return r;
  endfunction

  function automatic int unsigned clamp_pos(logic [PosW-1:0] p);
    if (p < 1) return 1;
    if (p > MaxPos) return MaxPos;
    return 32'(p);
  endfunction

  function automatic verdict_t judge_claim(logic [PosW-1:0] l, logic [PosW-1:0] r, bit odd);
    int unsigned u;
    int unsigned v;
    bit          clash;
    verdict_t    res;
    u = clamp_pos(l) - 1;
    v = clamp_pos(r);
    res.consistent = 1'b0;
    if (!clash_latched) begin
      if (odd)
        clash = find_root(u) == find_root(v) || find_root(u + Nodes) == find_root(v + Nodes);
      else
        clash = find_root(u) == find_root(v + Nodes) || find_root(u + Nodes) == find_root(v);
      if (clash) begin
        clash_latched = 1'b1;
      end else begin
        if (odd) begin
          parent_tbl[find_root(u)] = find_root(v + Nodes);
          parent_tbl[find_root(u + Nodes)] = find_root(v);
        end else begin
          parent_tbl[find_root(u)] = find_root(v);
          parent_tbl[find_root(u + Nodes)] = find_root(v + Nodes);
        end
        if (accepted_cnt != CountMax) accepted_cnt = accepted_cnt + 1'b1;
        res.consistent = 1'b1;
      end
    end
    res.seen = clash_latched;
    res.count = accepted_cnt;
    return res;
  endfunction

  // parity that agrees with the hidden bit string
  function automatic bit true_parity(logic [PosW-1:0] l, logic [PosW-1:0] r);
    return prefix_par[clamp_pos(l) - 1] ^ prefix_par[clamp_pos(r)];
  endfunction

  task automatic send_claim(logic [PosW-1:0] l, logic [PosW-1:0] r, bit odd);
    int unsigned gap;
    bit          taken;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    left_pos_i   = l;
    right_pos_i  = r;
    claims_odd_i = odd;
    forever begin
      taken = !in_stall_o;
      @(posedge clk_i);
      if (taken) break;
      @(negedge clk_i);
    end
    verdicts_q.push_back(judge_claim(l, r, odd));
    claims_sent++;
  endtask

  task automatic send_true(logic [PosW-1:0] l, logic [PosW-1:0] r);
    send_claim(l, r, true_parity(l, r));
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (verdicts_q.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [PosW-1:0] rand_pos();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k == 0) return PosW'($urandom_range(0, 2047));
    if (k < 5) return PosW'($urandom_range(1, 64));
    return PosW'($urandom_range(1, MaxPos));
  endfunction

  // receiver side
  initial begin
    int unsigned w;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (LongHold) @(negedge clk_i);
        hold_req = 1'b0;
      end
      w = no_idle ? 0 : $urandom_range(0, 8);
      if (w > 0) begin
        out_stall_i = 1'b1;
        repeat (w) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i) && !hold_req);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (verdicts_q.size() == 0) begin
        $error("result with no pending transaction");
        error_cnt++;
      end else begin
        want = verdicts_q.pop_front();
        if (consistent_o !== want.consistent) begin
          $error("consistent: expected %0d, got %0d", want.consistent, consistent_o);
          error_cnt++;
        end
        if (contradiction_seen_o !== want.seen) begin
          $error("contradiction_seen: expected %0d, got %0d", want.seen,
                 contradiction_seen_o);
          error_cnt++;
        end
        if (consistent_count_o !== want.count) begin
          $error("consistent_count: expected %0d, got %0d", want.count,
                 consistent_count_o);
          error_cnt++;
        end
      end
    end
  end

  task automatic test_directed();
    send_true(11'd1, 11'd1024);
    send_true(11'd1, 11'd1);
    send_true(11'd1024, 11'd1024);
    send_true(11'd0, 11'd5);
    send_true(11'd2047, 11'd3);
    send_true(11'd1500, 11'd0);
    send_true(11'd5, 11'd4);
    send_true(11'd700, 11'd300);
    send_true(11'd1025, 11'd1025);
    send_true(11'd1, 11'd1024);
    send_true(11'd2, 11'd1023);
    send_true(11'd1023, 11'd1);
    send_true(11'd512, 11'd513);
    send_true(11'd1025, 11'd1022);
    send_claim(11'd6, 11'd5, 1'b0);
    wait_drain();
  endtask

  task automatic test_random_consistent();
    for (int i = 0; i < 1700; i++) begin
      no_idle = (i >= 300 && i < 400);
      if (i == 800) hold_req = 1'b1;
      if (i == 1200) wait_drain();
      send_true(rand_pos(), rand_pos());
    end
    no_idle = 1'b0;
    wait_drain();
  endtask

  // flips a known relation, then the flag must stay latched
  task automatic test_contradiction();
    send_claim(11'd1, 11'd1024, ~true_parity(11'd1, 11'd1024));
    send_claim(11'd6, 11'd5, 1'b1);
    for (int i = 0; i < 20; i++) begin
      if (i % 2 == 0) send_true(rand_pos(), rand_pos());
      else send_claim(rand_pos(), rand_pos(), 1'($urandom_range(0, 1)));
    end
    wait_drain();
  endtask

  initial begin
    for (int i = 0; i < Depth; i++) parent_tbl[i] = i;
    prefix_par[0] = 1'b0;
    for (int i = 1; i < Nodes; i++)
      prefix_par[i] = prefix_par[i-1] ^ 1'($urandom_range(0, 1));
    clash_latched = 1'b0;
    accepted_cnt = '0;
    error_cnt = 0;
    claims_sent = 0;
    results_seen = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    in_valid_i = 1'b0;
    left_pos_i = '0;
    right_pos_i = '0;
    claims_odd_i = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_consistent();
    test_contradiction();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait_drain();
    repeat (100) @(negedge clk_i);
    if (verdicts_q.size() != 0) begin
      $error("%0d results never arrived", verdicts_q.size());
      error_cnt++;
    end
    $display("%0d claims sent, %0d results checked, %0d accepted before the contradiction",
             claims_sent, results_seen, accepted_cnt);
    if (error_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
